// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/erpd_pkg.sv
// ----------------------------------------------------------------------------
// erpd_pkg
// Types and constants of the escape-coded RLE pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package erpd_pkg;

	localparam int CAP_W  = 18;
	localparam int ADDR_W = 17;
	localparam int LEN_W  = 9;
	localparam int BYTE_W = 8;

	localparam logic [CAP_W-1:0]  CAP_RESET   = 18'd24192;
	localparam int                ADDR_REACH  = 131072;
	localparam logic [BYTE_W-1:0] ESCAPE_CODE = 8'd64;

	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_IDX_CAP = 1'b0;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LEN  = 2'd1,
		PH_VAL  = 2'd2
	} phase_t;

endpackage

`default_nettype wire

// File: src/escape_rle_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// escape_rle_pixel_decoder_top
// Escape-coded run-length pixel decoder producing buffer fill commands.
// ----------------------------------------------------------------------------
// Takes one compressed byte per clock and turns it into at most one fill
// command (address, value, length, clipped). A byte is held in the input
// register, decoded, and its command held in the result register; a new byte
// is accepted in every cycle while the result register is free or being
// drained. s_tready follows m_tready combinationally when both registers are
// full. Fill commands are clipped to the smallest of buffer_capacity,
// BUFFER_DEPTH and the 131072-byte reach of the 17-bit address.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_rle_pixel_decoder_top import erpd_pkg::*; #(
	parameter int BUFFER_DEPTH = 131072
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// stream in
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,  // [7:0] code_byte
	input  wire logic               s_tuser,  // [0] frame_start
	input  wire logic               s_tlast,  // chunk_end
	// stream out
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [39:0]        m_tdata,  // [16:0] fill_address, [24:17] fill_value,
	                                          // [33:25] fill_length, [39:34] zero
	output logic                    m_tuser,  // [0] clipped
	// APB
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	logic [CAP_W-1:0]  cap_eff;
	logic [ADDR_W-1:0] fill_address;
	logic [BYTE_W-1:0] fill_value;
	logic [LEN_W-1:0]  fill_length;
	logic              clipped;
	logic              chunk_end_unused;

	assign chunk_end_unused = s_tlast;

	erpd_cfg #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap_eff (cap_eff)
	);

	erpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap_eff   (cap_eff),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_fs     (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_addr  (fill_address),
		.out_value (fill_value),
		.out_len   (fill_length),
		.out_clip  (clipped)
	);

	assign m_tdata = {6'd0, fill_length, fill_value, fill_address};
	assign m_tuser = clipped;

endmodule

`default_nettype wire

// File: src/erpd_cfg.sv
// ----------------------------------------------------------------------------
// erpd_cfg
// APB register file: buffer capacity, clamped to the usable depth.
// ----------------------------------------------------------------------------
`default_nettype none

module erpd_cfg import erpd_pkg::*; #(
	parameter int BUFFER_DEPTH = 131072
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [31:0]         pwdata,
	output logic      [31:0]         prdata,
	output logic                     pready,
	output logic      [CAP_W-1:0]    cap_eff
);

	localparam int CAP_LIMIT = (BUFFER_DEPTH < ADDR_REACH) ? BUFFER_DEPTH : ADDR_REACH;
	localparam logic [CAP_W-1:0] CAP_LIMIT_V = CAP_W'(CAP_LIMIT);

	logic [CAP_W-1:0] cap_q;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_IDX_CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(32-CAP_W){1'b0}}, cap_q};
		end
	end

	assign cap_eff = (cap_q > CAP_LIMIT_V) ? CAP_LIMIT_V : cap_q;

endmodule

`default_nettype wire

// File: src/erpd_core.sv
// ----------------------------------------------------------------------------
// erpd_core
// Input register, escape decode and clipping, fill command result register.
// ----------------------------------------------------------------------------
`default_nettype none

module erpd_core import erpd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [CAP_W-1:0]   cap_eff,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [BYTE_W-1:0]  in_byte,
	input  wire logic               in_fs,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [ADDR_W-1:0]  out_addr,
	output logic      [BYTE_W-1:0]  out_value,
	output logic      [LEN_W-1:0]   out_len,
	output logic                    out_clip
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              fs_s1;

	phase_t            phase_q, phase_d, phase_eff;
	logic [LEN_W-1:0]  pend_q, pend_d;
	logic [CAP_W-1:0]  off_q, off_d, off_eff;

	logic [CAP_W-1:0]  room;
	logic [LEN_W-1:0]  n_len;
	logic              n_clip;
	logic              emit;

	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] value_q;
	logic [LEN_W-1:0]  len_q;
	logic              clip_q;

	logic              adv;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			fs_s1   <= in_fs;
		end
	end

	always_comb begin
		off_eff   = fs_s1 ? '0 : off_q;
		phase_eff = fs_s1 ? PH_IDLE : phase_q;
		room      = (off_eff < cap_eff) ? (cap_eff - off_eff) : '0;

		phase_d = PH_IDLE;
		pend_d  = fs_s1 ? '0 : pend_q;
		off_d   = off_eff;
		n_len   = '0;
		n_clip  = 1'b0;
		emit    = 1'b0;

		case (phase_eff)
			PH_LEN: begin
				pend_d  = LEN_W'(byte_s1) + LEN_W'(1);
				phase_d = PH_VAL;
			end
			PH_VAL: begin
				pend_d = '0;
				n_len  = pend_d;
				n_len  = fs_s1 ? '0 : pend_q;
				if ({{(CAP_W-LEN_W){1'b0}}, n_len} > room) begin
					n_len  = room[LEN_W-1:0];
					n_clip = 1'b1;
				end
				emit  = (n_len != '0);
				off_d = off_eff + {{(CAP_W-LEN_W){1'b0}}, n_len};
			end
			default: begin
				if (byte_s1 < ESCAPE_CODE) begin
					if (room != '0) begin
						emit  = 1'b1;
						n_len = LEN_W'(1);
						off_d = off_eff + CAP_W'(1);
					end
				end else if (byte_s1 == ESCAPE_CODE) begin
					phase_d = PH_LEN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pend_q      <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q     <= phase_d;
				pend_q      <= pend_d;
				off_q       <= off_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			addr_q  <= off_eff[ADDR_W-1:0];
			value_q <= byte_s1;
			len_q   <= n_len;
			clip_q  <= n_clip;
		end
	end

	assign out_valid = out_valid_q;
	assign out_addr  = addr_q;
	assign out_value = value_q;
	assign out_len   = len_q;
	assign out_clip  = clip_q;

endmodule

`default_nettype wire

// File: src/erpd_checker.sv
// ----------------------------------------------------------------------------
// erpd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module erpd_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tready,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [39:0]        m_tdata,
	input wire logic               m_tuser
);

	logic [17:0] fill_end;

	assign fill_end = {1'b0, m_tdata[16:0]} + {9'd0, m_tdata[33:25]};

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_IMPL(a_len_range, clk, arst_n, m_tvalid,
		m_tdata[33:25] != 9'd0 && m_tdata[33:25] <= 9'd256)
	`ASSERT_IMPL(a_in_buffer, clk, arst_n, m_tvalid, fill_end <= 18'd131072)
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind escape_rle_pixel_decoder_top erpd_checker u_chk (.*);

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape-coded RLE pixel decoder.
// ----------------------------------------------------------------------------
// Drives compressed bytes into the stream input and predicts every fill
// command in a behavioral model kept inside the bench. Each accepted output
// transfer is compared with the oldest predicted command. The run opens with
// a directed table of literals, escapes, ignored bytes, frame starts and
// clipping at several capacities. Random phases follow, each at a different
// capacity, with random gaps on both sides. One phase holds the output off
// for a long stretch. Capacity is written and read back over APB only while
// the decoder is drained.
// ----------------------------------------------------------------------------

module tb import erpd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 95;
	localparam int N_PHASES     = 8;
	localparam int N_ROWS       = 31;
	localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * int'(REG_IDX_CAP));

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] value;
		logic [LEN_W-1:0]  length;
		logic              clipped;
	} fill_cmd_t;

	typedef struct packed {
		bit                cfg;
		logic [CAP_W-1:0]  cap;
		logic [BYTE_W-1:0] code;
		bit                fs;
		bit                ce;
		bit                typed;
		bit                has_fill;
		fill_cmd_t         fill;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // [7:0] code_byte
	logic        s_tuser;  // [0] frame_start
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // [16:0] fill_address, [24:17] fill_value, [33:25] fill_length
	logic        m_tuser;  // [0] clipped
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// decoder model state
	phase_t             dec_phase;
	logic [LEN_W-1:0]   run_len;
	logic [CAP_W-1:0]   wr_off;
	logic [CAP_W-1:0]   cap_reg;

	fill_cmd_t fills_due[$];
	int        errors;
	int        cycles;
	int        items_done;
	bit        hold_req;

	escape_rle_pixel_decoder_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	step_row_t dir_rows [N_ROWS] = '{
		'{0, 0,   0, 1, 0, 1, 1, '{0, 0, 1, 0}},
		'{0, 0,  63, 0, 1, 1, 1, '{1, 63, 1, 0}},
		'{0, 0,  65, 0, 0, 1, 0, '0},
		'{0, 0, 255, 0, 1, 1, 0, '0},
		'{0, 0,  64, 0, 0, 1, 0, '0},
		'{0, 0, 255, 0, 0, 1, 0, '0},
		'{0, 0, 255, 0, 0, 1, 1, '{2, 255, 256, 0}},
		'{0, 0,  64, 0, 0, 1, 0, '0},
		'{0, 0,   0, 0, 0, 1, 0, '0},
		'{0, 0,   0, 0, 1, 1, 1, '{258, 0, 1, 0}},
		'{0, 0,  64, 0, 0, 0, 0, '0},
		'{0, 0,  64, 0, 0, 0, 0, '0},
		'{0, 0, 128, 0, 0, 0, 0, '0},
		'{0, 0,  64, 0, 0, 1, 0, '0},
		// frame start drops the open escape
		'{0, 0,   7, 1, 0, 1, 1, '{0, 7, 1, 0}},
		'{1, 0,   0, 0, 0, 0, 0, '0},
		'{0, 0,   5, 1, 0, 1, 0, '0},
		'{0, 0,  64, 0, 0, 1, 0, '0},
		'{0, 0,   3, 0, 0, 1, 0, '0},
		'{0, 0,   9, 0, 1, 1, 0, '0},
		'{1, 1,   0, 0, 0, 0, 0, '0},
		'{0, 0,  42, 1, 1, 1, 1, '{0, 42, 1, 0}},
		'{0, 0,   1, 0, 0, 1, 0, '0},
		'{1, 5,   0, 0, 0, 0, 0, '0},
		'{0, 0,  64, 1, 0, 1, 0, '0},
		'{0, 0,   9, 0, 0, 1, 0, '0},
		'{0, 0, 200, 0, 1, 1, 1, '{0, 200, 5, 1}},
		// capacity above the address reach is limited
		'{1, 262143, 0, 0, 0, 0, 0, '0},
		'{0, 0,  64, 0, 0, 1, 0, '0},
		'{0, 0, 255, 0, 0, 1, 0, '0},
		'{0, 0,  17, 0, 1, 1, 1, '{5, 17, 256, 0}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit decode_step(input logic [7:0] b, input bit fs, output fill_cmd_t cmd);
		int lim;
		int room;
		int n;
		bit clip;
		// BUFFER_DEPTH left at its default, equal to the address reach
		lim = (int'(cap_reg) > ADDR_REACH) ? ADDR_REACH : int'(cap_reg);
		room = (int'(wr_off) < lim) ? lim - int'(wr_off) : 0;
		cmd = '0;
		if (fs) begin
			wr_off = '0;
			dec_phase = PH_IDLE;
			run_len = '0;
			room = lim;
		end
		case (dec_phase)
			PH_LEN: begin
				run_len = LEN_W'(b) + 9'd1;
				dec_phase = PH_VAL;
				return 0;
			end
			PH_VAL: begin
				n = int'(run_len);
				clip = 1'b0;
				dec_phase = PH_IDLE;
				run_len = '0;
				if (n > room) begin
					n = room;
					clip = 1'b1;
				end
				if (n == 0)
					return 0;
				cmd = '{wr_off[ADDR_W-1:0], b, LEN_W'(n), clip};
				wr_off = wr_off + CAP_W'(n);
				return 1;
			end
			default: begin
				dec_phase = PH_IDLE;
				if (b < ESCAPE_CODE) begin
					if (room == 0)
						return 0;
					cmd = '{wr_off[ADDR_W-1:0], b, 9'd1, 1'b0};
					wr_off = wr_off + 18'd1;
					return 1;
				end
				if (b == ESCAPE_CODE)
					dec_phase = PH_LEN;
				return 0;
			end
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic push_byte(input logic [7:0] b, input bit fs, input bit ce, input int gap,
			output bit has, output fill_cmd_t cmd);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= fs;
		s_tlast <= ce;
		do @(posedge clk); while (!s_tready);
		if (!(dec_phase == PH_IDLE && b > ESCAPE_CODE && !fs))
			items_done++;
		has = decode_step(b, fs, cmd);
		@(negedge clk);
	endtask

	task automatic emit_byte(input logic [7:0] b, input bit calm);
		bit has;
		fill_cmd_t cmd;
		push_byte(b, $urandom_range(0, 29) == 0, $urandom_range(0, 7) == 0,
			calm ? 0 : pick_gap(), has, cmd);
		if (has)
			fills_due.push_back(cmd);
	endtask

	task automatic send_token(input bit calm);
		int kind;
		logic [7:0] len_byte;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			emit_byte(8'($urandom_range(0, 63)), calm);
		end else if (kind < 80) begin
			if ($urandom_range(0, 3) == 0)
				len_byte = 8'd255;
			else if ($urandom_range(0, 1) == 0)
				len_byte = 8'($urandom_range(0, 15));
			else
				len_byte = 8'($urandom_range(0, 255));
			emit_byte(ESCAPE_CODE, calm);
			emit_byte(len_byte, calm);
			emit_byte(8'($urandom_range(0, 255)), calm);
		end else if (kind < 90) begin
			emit_byte(8'($urandom_range(65, 255)), calm);
		end else begin
			emit_byte(8'($urandom_range(0, 255)), calm);
		end
	endtask

	// wait out every pending fill plus anything still in the pipe
	task automatic settle();
		s_tvalid <= 1'b0;
		while (fills_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic check_capacity(input logic [CAP_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAP_ADDR;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(value))
			note_error($sformatf("capacity readback: exp %0d got %0d", value, prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= 32'(value);
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		cap_reg = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		check_capacity(value);
	endtask

	// output side: random stalls, calm windows, one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if ((cycles / 256) % 3 != 2 && $urandom_range(0, 7) == 0)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
						: $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		fill_cmd_t got;
		fill_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[16:0], m_tdata[24:17], m_tdata[33:25], m_tuser};
			if (fills_due.size() == 0) begin
				note_error($sformatf("fill with nothing expected: addr=%0d val=%0d len=%0d clip=%0d",
					got.addr, got.value, got.length, got.clipped));
			end else begin
				want = fills_due.pop_front();
				if (got.addr !== want.addr || got.value !== want.value
						|| got.length !== want.length || got.clipped !== want.clipped)
					note_error($sformatf({"fill mismatch: exp addr=%0d val=%0d len=%0d clip=%0d",
						" got addr=%0d val=%0d len=%0d clip=%0d"},
						want.addr, want.value, want.length, want.clipped,
						got.addr, got.value, got.length, got.clipped));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		bit has;
		fill_cmd_t cmd;
		int start;
		logic [CAP_W-1:0] cap_val;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		items_done = 0;
		hold_req = 1'b0;
		dec_phase = PH_IDLE;
		run_len = '0;
		wr_off = '0;
		cap_reg = CAP_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_capacity(CAP_RESET);
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (dir_rows[i].cfg) begin
				settle();
				set_capacity(dir_rows[i].cap);
				@(negedge clk);
			end else begin
				push_byte(dir_rows[i].code, dir_rows[i].fs, dir_rows[i].ce, pick_gap(), has, cmd);
				if (dir_rows[i].typed) begin
					has = dir_rows[i].has_fill;
					cmd = dir_rows[i].fill;
				end
				if (has)
					fills_due.push_back(cmd);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: cap_val = 18'd131072;
				1: cap_val = 18'h3FFFF;
				2: cap_val = 18'd0;
				3: cap_val = 18'd1;
				4: cap_val = 18'd700;
				5: cap_val = 18'd3000;
				6: cap_val = CAP_W'($urandom_range(0, 262143));
				default: cap_val = CAP_W'($urandom_range(2, 400));
			endcase
			settle();
			set_capacity(cap_val);
			@(negedge clk);
			if (p == 1) begin
				// long output hold while input keeps streaming
				hold_req = 1'b1;
				repeat (40) emit_byte(8'($urandom_range(0, 63)), 1'b1);
			end
			start = items_done;
			while (items_done - start < PHASE_ITEMS)
				send_token(p % 3 == 1);
		end

		s_tvalid <= 1'b0;
		while (fills_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
